// ===== src/assert_macros.svh =====
// Assertion macros shared by the fill block RTL.
// Each macro samples on the rising edge of clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous reset disable.
`define MDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: the consequent must hold in the same cycle.
`define MDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/mdf_pkg.sv =====
// Package for the masked image diffusion fill block: types, constants and tap tables.
// No dependencies.
`default_nettype none

package mdf_pkg;

  // Default frame limits.
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int DEF_MAX_HEIGHT = 128;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [7:0] RST_WIDTH  = 8'd128;
  localparam logic [7:0] RST_HEIGHT = 8'd128;
  localparam logic [7:0] RST_THRESH = 8'd100;

  // Datapath widths.
  localparam int PIX_W  = 16;
  localparam int WGT_W  = 5;
  localparam int NUM_W  = 24;
  localparam int DEN_W  = 8;
  localparam int TAP_IW = 5;
  localparam int DIV_CW = 5;

  localparam logic [TAP_IW-1:0] TAP_LAST  = TAP_IW'(19);
  localparam logic [TAP_IW-1:0] TAP_NEAR  = TAP_IW'(4);
  localparam logic [DIV_CW-1:0] DIV_LAST  = DIV_CW'(NUM_W - 1);

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_LOAD = 2'd0,
    PH_FILL = 2'd1,
    PH_READ = 2'd2
  } phase_e;

  typedef enum logic [3:0] {
    F_IDLE,
    F_WAIT,
    F_PIX_RD,
    F_PIX_CHK,
    F_TAP_ADDR,
    F_TAP_RD,
    F_TAP_ACC,
    F_DIV_INIT,
    F_DIV,
    F_WRITE,
    F_NEXT,
    F_COPY_RD,
    F_COPY_WR
  } fill_state_e;

  // Horizontal offset of each window tap.
  function automatic logic signed [2:0] tap_dx(input logic [TAP_IW-1:0] t);
    logic signed [2:0] r;
    case (t)
      5'd0, 5'd3, 5'd8, 5'd11:          r = 3'sd0;
      5'd1, 5'd5, 5'd7, 5'd14, 5'd18:   r = -3'sd1;
      5'd2, 5'd4, 5'd6, 5'd12, 5'd16:   r = 3'sd1;
      5'd9, 5'd15, 5'd19:               r = -3'sd2;
      5'd10, 5'd13, 5'd17:              r = 3'sd2;
      default:                          r = 3'sd0;
    endcase
    return r;
  endfunction

  // Vertical offset of each window tap.
  function automatic logic signed [2:0] tap_dy(input logic [TAP_IW-1:0] t);
    logic signed [2:0] r;
    case (t)
      5'd1, 5'd2, 5'd9, 5'd10:          r = 3'sd0;
      5'd0, 5'd4, 5'd5, 5'd13, 5'd15:   r = -3'sd1;
      5'd3, 5'd6, 5'd7, 5'd17, 5'd19:   r = 3'sd1;
      5'd8, 5'd12, 5'd14:               r = -3'sd2;
      5'd11, 5'd16, 5'd18:              r = 3'sd2;
      default:                          r = 3'sd0;
    endcase
    return r;
  endfunction

  // Weight of each tap: 20, 15, 10 and 6 stand for 1, 0.75, 0.5 and 0.3.
  function automatic logic [WGT_W-1:0] tap_w(input logic [TAP_IW-1:0] t);
    logic [WGT_W-1:0] r;
    if (t < 5'd4) begin
      r = 5'd20;
    end else if (t < 5'd8) begin
      r = 5'd15;
    end else if (t < 5'd12) begin
      r = 5'd10;
    end else begin
      r = 5'd6;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mdf_in_if.sv =====
// Input channel of the fill block: valid/ready handshake with a command and pixel payload.
// No dependencies.
`default_nettype none

interface mdf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pixel_value;
  logic [7:0] mask_value;

  modport source (output valid, cmd, pixel_value, mask_value, input ready);
  modport sink   (input valid, cmd, pixel_value, mask_value, output ready);
endinterface

`default_nettype wire

// ===== src/mdf_out_if.sv =====
// Output channel of the fill block: valid/ready handshake with a filled pixel payload.
// No dependencies.
`default_nettype none

interface mdf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filled_value;
  logic        last_pixel;

  modport source (output valid, filled_value, last_pixel, input ready);
  modport sink   (input valid, filled_value, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== src/masked_image_diffusion_fill.sv =====
// Masked image diffusion fill, top level. Loads are accepted one per cycle. After the last
// load the block waits for the output register to drain; then each fill round checks the
// mark of every pixel, and an unknown pixel addresses, reads and accumulates its 20 taps
// through the one read port and, if filled, runs the 24-step shared divider and a write-back.
// After a round that changed something the marks are copied. Reads deliver a result in the
// cycle after acceptance, one per cycle unless out_o stalls. rst_ni low (async) resets ctrl regs.
`default_nettype none
`include "assert_macros.svh"

module masked_image_diffusion_fill #(
  parameter int MAX_WIDTH  = mdf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = mdf_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mdf_in_if.sink                              in_i,
  mdf_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [mdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mdf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mdf_pkg::*;

  localparam int MEM_D = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(MEM_D);
  localparam int NW    = $clog2(MEM_D + 1);
  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int XS    = XB + 2;
  localparam int YS    = YB + 2;

  // Configuration registers and effective geometry.
  logic [7:0] cfg_w_q, cfg_h_q, thr_q;
  logic [WB-1:0] eff_w;
  logic [HB-1:0] eff_h;
  logic [NW-1:0] n_pix;

  assign eff_w = (cfg_w_q == 8'd0) ? WB'(1) :
                 ((32'(cfg_w_q) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(cfg_w_q));
  assign eff_h = (cfg_h_q == 8'd0) ? HB'(1) :
                 ((32'(cfg_h_q) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(cfg_h_q));
  assign n_pix = NW'(eff_w) * NW'(eff_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RST_WIDTH;
      cfg_h_q <= RST_HEIGHT;
      thr_q   <= RST_THRESH;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  cfg_w_q <= cfg_data_i;
        CFG_HEIGHT: cfg_h_q <= cfg_data_i;
        CFG_THRESH: thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic cfg_hit;
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT ||
                                cfg_idx_i == CFG_THRESH);

  // State and datapath registers.
  phase_e             phase_q, phase_d;
  fill_state_e        st_q, st_d;
  logic [AW-1:0]      ld_pos_q, ld_pos_d, rd_pos_q, rd_pos_d, pos_q, pos_d, addr_q, addr_d;
  logic [XB-1:0]      x_q, x_d;
  logic [YB-1:0]      y_q, y_d;
  logic [TAP_IW-1:0]  tap_q, tap_d;
  logic [NUM_W-1:0]   num_q, num_d, quo_q, quo_d;
  logic [DEN_W-1:0]   den_q, den_d;
  logic [DEN_W:0]     rem_q, rem_d;
  logic [DIV_CW-1:0]  div_cnt_q, div_cnt_d;
  logic               near_q, near_d, changed_q, changed_d;
  logic               out_valid_q, out_valid_d, last_q, last_d;

  // Memories and their ports.
  logic [PIX_W-1:0] pix_mem [MEM_D];
  logic             kn_now_mem [MEM_D];
  logic             kn_next_mem [MEM_D];
  logic [PIX_W-1:0] pix_rdata_q, pix_wdata;
  logic             kn_now_rdata_q, kn_next_rdata_q, kn_now_wdata;
  logic             pix_we, pix_re, kn_now_we, kn_now_re, kn_next_we, kn_next_re;
  logic [AW-1:0]    pix_waddr, pix_raddr, kn_now_waddr, kn_now_raddr, kn_next_waddr;

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[pix_waddr] <= pix_wdata;
    end
    if (pix_re) begin
      pix_rdata_q <= pix_mem[pix_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kn_now_we) begin
      kn_now_mem[kn_now_waddr] <= kn_now_wdata;
    end
    if (kn_now_re) begin
      kn_now_rdata_q <= kn_now_mem[kn_now_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (kn_next_we) begin
      kn_next_mem[kn_next_waddr] <= kn_now_wdata | (st_q == F_WRITE);
    end
    if (kn_next_re) begin
      kn_next_rdata_q <= kn_next_mem[pos_q];
    end
  end

  // Input handshake and transaction decode.
  logic in_acc, ld_acc, rd_acc, ld_last, rd_last, out_take, pos_last, x_last, tap_known;
  assign in_i.ready = (phase_q == PH_LOAD) ||
                      ((phase_q == PH_READ) && (!out_valid_q || out_o.ready));
  assign in_acc   = in_i.valid && in_i.ready;
  assign ld_acc   = in_acc && (phase_q == PH_LOAD) && !in_i.cmd;
  assign rd_acc   = in_acc && (phase_q == PH_READ) && in_i.cmd;
  assign ld_last  = ld_acc && (ld_pos_q == AW'(n_pix - NW'(1)));
  assign rd_last  = rd_pos_q == AW'(n_pix - NW'(1));
  assign out_take = out_valid_q && out_o.ready;
  assign pos_last = pos_q == AW'(n_pix - NW'(1));
  assign x_last   = x_q == XB'(eff_w - WB'(1));
  assign tap_known = kn_now_rdata_q;

  assign out_o.valid        = out_valid_q;
  assign out_o.filled_value = pix_rdata_q;
  assign out_o.last_pixel   = last_q;

  // Clamped tap address.
  logic signed [XS-1:0] sx;
  logic signed [YS-1:0] sy;
  logic [XB-1:0]        cx;
  logic [YB-1:0]        cy;
  always_comb begin
    sx = $signed({2'b00, x_q}) + XS'(tap_dx(tap_q));
    sy = $signed({2'b00, y_q}) + YS'(tap_dy(tap_q));
    if (sx < 0) begin
      cx = '0;
    end else if (sx >= $signed({{(XS-WB){1'b0}}, eff_w})) begin
      cx = XB'(eff_w - WB'(1));
    end else begin
      cx = sx[XB-1:0];
    end
    if (sy < 0) begin
      cy = '0;
    end else if (sy >= $signed({{(YS-HB){1'b0}}, eff_h})) begin
      cy = YB'(eff_h - HB'(1));
    end else begin
      cy = sy[YB-1:0];
    end
  end

  // Sequencer next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE:     if (ld_last) st_d = F_WAIT;
      F_WAIT:     if (!out_valid_q) st_d = F_PIX_RD;
      F_PIX_RD:   st_d = F_PIX_CHK;
      F_PIX_CHK:  st_d = kn_now_rdata_q ? F_NEXT : F_TAP_ADDR;
      F_TAP_ADDR: st_d = F_TAP_RD;
      F_TAP_RD:   st_d = F_TAP_ACC;
      F_TAP_ACC: begin
        if (tap_q == TAP_LAST) begin
          st_d = near_d ? F_DIV_INIT : F_NEXT;
        end else begin
          st_d = F_TAP_ADDR;
        end
      end
      F_DIV_INIT: st_d = F_DIV;
      F_DIV:      if (div_cnt_q == DIV_LAST) st_d = F_WRITE;
      F_WRITE:    st_d = F_NEXT;
      F_NEXT: begin
        if (pos_last) begin
          st_d = changed_q ? F_COPY_RD : F_IDLE;
        end else begin
          st_d = F_PIX_RD;
        end
      end
      F_COPY_RD:  st_d = F_COPY_WR;
      F_COPY_WR:  st_d = pos_last ? F_PIX_RD : F_COPY_RD;
      default:    st_d = F_IDLE;
    endcase
    if (cfg_hit) begin
      st_d = F_IDLE;
    end
  end

  // Datapath and memory controls.
  logic [DEN_W:0] rem_sh;
  always_comb begin
    phase_d     = phase_q;
    ld_pos_d    = ld_pos_q;
    rd_pos_d    = rd_pos_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    x_d         = x_q;
    y_d         = y_q;
    tap_d       = tap_q;
    num_d       = num_q;
    den_d       = den_q;
    near_d      = near_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    changed_d   = changed_q;
    out_valid_d = out_valid_q && !out_take;
    last_d      = last_q;
    rem_sh      = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};

    pix_we        = 1'b0;
    pix_waddr     = ld_pos_q;
    pix_wdata     = {in_i.pixel_value, 8'h00};
    pix_re        = 1'b0;
    pix_raddr     = addr_q;
    kn_now_we     = 1'b0;
    kn_now_waddr  = ld_pos_q;
    kn_now_wdata  = in_i.mask_value >= thr_q;
    kn_now_re     = 1'b0;
    kn_now_raddr  = pos_q;
    kn_next_we    = 1'b0;
    kn_next_waddr = ld_pos_q;
    kn_next_re    = 1'b0;

    // Load and read transactions.
    if (ld_acc) begin
      pix_we     = 1'b1;
      kn_now_we  = 1'b1;
      kn_next_we = 1'b1;
      ld_pos_d   = ld_pos_q + AW'(1);
      if (ld_last) begin
        phase_d   = PH_FILL;
        pos_d     = '0;
        x_d       = '0;
        y_d       = '0;
        changed_d = 1'b0;
      end
    end
    if (rd_acc) begin
      pix_re      = 1'b1;
      pix_raddr   = rd_pos_q;
      out_valid_d = 1'b1;
      last_d      = rd_last;
      rd_pos_d    = rd_pos_q + AW'(1);
      if (rd_last) begin
        phase_d  = PH_LOAD;
        ld_pos_d = '0;
        rd_pos_d = '0;
      end
    end

    // Fill sequencer work.
    case (st_q)
      F_PIX_RD: kn_now_re = 1'b1;
      F_PIX_CHK: begin
        tap_d  = '0;
        num_d  = '0;
        den_d  = '0;
        near_d = 1'b0;
      end
      F_TAP_ADDR: addr_d = AW'(AW'(cy) * AW'(eff_w) + AW'(cx));
      F_TAP_RD: begin
        pix_re       = 1'b1;
        kn_now_re    = 1'b1;
        kn_now_raddr = addr_q;
      end
      F_TAP_ACC: begin
        if (tap_known) begin
          num_d = num_q + NUM_W'(tap_w(tap_q) * pix_rdata_q);
          den_d = den_q + DEN_W'(tap_w(tap_q));
          if (tap_q < TAP_NEAR) begin
            near_d = 1'b1;
          end
        end
        tap_d = tap_q + TAP_IW'(1);
      end
      F_DIV_INIT: begin
        quo_d     = num_q + NUM_W'(den_q >> 1);
        rem_d     = '0;
        div_cnt_d = '0;
      end
      F_DIV: begin
        // One restoring division step per cycle.
        if (rem_sh >= {1'b0, den_q}) begin
          rem_d = rem_sh - {1'b0, den_q};
          quo_d = {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[NUM_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DIV_CW'(1);
      end
      F_WRITE: begin
        pix_we        = den_q != '0;
        pix_waddr     = pos_q;
        pix_wdata     = quo_q[PIX_W-1:0];
        kn_next_we    = 1'b1;
        kn_next_waddr = pos_q;
        changed_d     = 1'b1;
      end
      F_NEXT: begin
        if (pos_last) begin
          pos_d = '0;
          x_d   = '0;
          y_d   = '0;
          if (!changed_q) begin
            phase_d  = PH_READ;
            rd_pos_d = '0;
          end
        end else begin
          pos_d = pos_q + AW'(1);
          if (x_last) begin
            x_d = '0;
            y_d = y_q + YB'(1);
          end else begin
            x_d = x_q + XB'(1);
          end
        end
      end
      F_COPY_RD: kn_next_re = 1'b1;
      F_COPY_WR: begin
        // New marks take effect for the next round.
        kn_now_we    = 1'b1;
        kn_now_waddr = pos_q;
        kn_now_wdata = kn_next_rdata_q;
        if (pos_last) begin
          pos_d     = '0;
          changed_d = 1'b0;
        end else begin
          pos_d = pos_q + AW'(1);
        end
      end
      default: ;
    endcase

    // Any register write restarts the frame.
    if (cfg_hit) begin
      phase_d  = PH_LOAD;
      ld_pos_d = '0;
      rd_pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LOAD;
      st_q        <= F_IDLE;
      ld_pos_q    <= '0;
      rd_pos_q    <= '0;
      changed_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      st_q        <= st_d;
      ld_pos_q    <= ld_pos_d;
      rd_pos_q    <= rd_pos_d;
      changed_q   <= changed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    addr_q    <= addr_d;
    x_q       <= x_d;
    y_q       <= y_d;
    tap_q     <= tap_d;
    num_q     <= num_d;
    den_q     <= den_d;
    near_q    <= near_d;
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    div_cnt_q <= div_cnt_d;
    last_q    <= last_d;
  end

  // Checks on the sequencer and phase.
  `MDF_ASSERT_IMP(a_fill_busy, phase_q == PH_FILL, !in_i.ready, "input ready during fill")
  `MDF_ASSERT_IMP(a_seq_in_fill, st_q != F_IDLE, phase_q == PH_FILL, "sequencer runs outside fill")
  `MDF_ASSERT_IMP(a_div_den, st_q == F_DIV, den_q != '0, "division by a zero weight sum")
  `MDF_ASSERT(a_fill_done, (st_q == F_NEXT && pos_last && !changed_q && !cfg_hit) |=>
              (phase_q == PH_READ), "fill end did not enter readout")

endmodule

`default_nettype wire

// ===== verif/mdf_fill_checker.sv =====
// Checker for the masked image diffusion fill block: watches both channels and the
// configuration port, predicts every readout pixel and compares. Depends on mdf_pkg and
// on the channel interfaces mdf_in_if and mdf_out_if.
`timescale 1ns / 100ps

module mdf_fill_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mdf_in_if                                   in_m,
  mdf_out_if                                  out_m,
  input  wire logic                           cfg_we_i,
  input  wire logic [mdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mdf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                  err_o,
  output int                                  pending_o
);
  import mdf_pkg::*;

  localparam int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

  typedef struct {
    logic [15:0] value;
    logic        last;
  } pixel_exp_t;

  // Window taps: offsets and weights, 4-neighbours first.
  localparam int OFS_X[20] = '{0, -1, 1, 0, 1, -1, 1, -1, 0, -2, 2, 0,
                               1, 2, -1, -2, 1, 2, -1, -2};
  localparam int OFS_Y[20] = '{-1, 0, 0, 1, -1, -1, 1, 1, -2, 0, 0, 2,
                               -2, -1, -2, -1, 2, 1, 2, 1};
  localparam int WGT[20]   = '{20, 20, 20, 20, 15, 15, 15, 15, 10, 10, 10, 10,
                               6, 6, 6, 6, 6, 6, 6, 6};

  logic [7:0]  width_q, height_q, thresh_q;
  logic [15:0] image_q[DEPTH];
  bit          known_cur[DEPTH];
  bit          known_nxt[DEPTH];
  int          load_pos, read_pos;
  phase_e      phase_q;
  pixel_exp_t  pixel_expq[$];

  assign pending_o = pixel_expq.size();

  function automatic int clamp_dim(logic [7:0] v, int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int clamp_pos(int v, int size);
    if (v < 0) return 0;
    if (v >= size) return size - 1;
    return v;
  endfunction

  // Run the fill rounds until a round changes nothing.
  task automatic diffuse(int w, int h);
    bit          changed;
    bit          near;
    int unsigned num, den;
    int          i, j;
    for (int k = 0; k < w * h; k++) known_nxt[k] = known_cur[k];
    do begin
      changed = 0;
      for (int y = 0; y < h; y++) begin
        for (int x = 0; x < w; x++) begin
          i = y * w + x;
          if (!known_cur[i]) begin
            near = 0;
            for (int t = 0; t < 4; t++) begin
              j = clamp_pos(y + OFS_Y[t], h) * w + clamp_pos(x + OFS_X[t], w);
              if (known_cur[j]) near = 1;
            end
            if (near) begin
              num = 0;
              den = 0;
              for (int t = 0; t < 20; t++) begin
                j = clamp_pos(y + OFS_Y[t], h) * w + clamp_pos(x + OFS_X[t], w);
                if (known_cur[j]) begin
                  num += WGT[t] * image_q[j];
                  den += WGT[t];
                end
              end
              if (den != 0) image_q[i] = 16'((num + den / 2) / den);
              known_nxt[i] = 1;
              changed = 1;
            end
          end
        end
      end
      for (int k = 0; k < w * h; k++) known_cur[k] = known_nxt[k];
    end while (changed);
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    err_o++;
  endtask

  // Track configuration and predict on every accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_exp_t e;
    int         w, h;
    if (!rst_ni) begin
      width_q  = RST_WIDTH;
      height_q = RST_HEIGHT;
      thresh_q = RST_THRESH;
      phase_q  = PH_LOAD;
      load_pos = 0;
      read_pos = 0;
      err_o    = 0;
      pixel_expq.delete();
    end else begin
      w = clamp_dim(width_q, DEF_MAX_WIDTH);
      h = clamp_dim(height_q, DEF_MAX_HEIGHT);
      // Output side first: results are compared with the oldest prediction.
      if (out_m.valid && out_m.ready) begin
        if (pixel_expq.size() == 0) begin
          report("unexpected pixel", out_m.filled_value, 16'h0);
        end else begin
          e = pixel_expq.pop_front();
          if (out_m.filled_value !== e.value) report("filled_value", out_m.filled_value, e.value);
          if (out_m.last_pixel !== e.last) begin
            report("last_pixel", 16'(out_m.last_pixel), 16'(e.last));
          end
        end
      end
      if (in_m.valid && in_m.ready) begin
        if (in_m.cmd == 1'b0) begin
          if (phase_q == PH_LOAD && load_pos < w * h) begin
            image_q[load_pos]   = {in_m.pixel_value, 8'h00};
            known_cur[load_pos] = in_m.mask_value >= thresh_q;
            known_nxt[load_pos] = known_cur[load_pos];
            load_pos++;
            if (load_pos >= w * h) begin
              diffuse(w, h);
              phase_q  = PH_READ;
              read_pos = 0;
            end
          end
        end else if (phase_q == PH_READ && read_pos < w * h) begin
          e.value = image_q[read_pos];
          e.last  = (read_pos + 1 == w * h);
          pixel_expq.push_back(e);
          read_pos++;
          if (read_pos >= w * h) begin
            phase_q  = PH_LOAD;
            load_pos = 0;
            read_pos = 0;
          end
        end
      end
      // A write to an existing register restarts the frame; other indexes are ignored.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_q  = cfg_data_i;
          CFG_HEIGHT: height_q = cfg_data_i;
          CFG_THRESH: thresh_q = cfg_data_i;
          default:    ;
        endcase
        if (cfg_idx_i inside {CFG_WIDTH, CFG_HEIGHT, CFG_THRESH}) begin
          phase_q  = PH_LOAD;
          load_pos = 0;
          read_pos = 0;
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for masked_image_diffusion_fill: clock, reset, stimulus, idling and verdict.
// Depends on mdf_pkg, the channel interfaces, the block and mdf_fill_checker.
`timescale 1ns / 100ps

module tb;
  import mdf_pkg::*;

  localparam int ITEM_GOAL = 1650;
  localparam int STALL_LIMIT = 5000000;
  localparam int SETTLE = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int err_cnt, pending;
  int sent = 0;
  int tx_idle = 17, rx_idle = 88;
  int hold_req = 0, hold_ack = 0;
  bit hold_next = 1'b0;
  int quiet = 0;

  mdf_in_if  in_if ();
  mdf_out_if out_if ();

  masked_image_diffusion_fill dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if.sink), .out_o(out_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  mdf_fill_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_m(in_if), .out_m(out_if),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .err_o(err_cnt), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off once a result is waiting.
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      out_if.ready = 1'b0;
      while (!out_if.valid) @(negedge clk_i);
      repeat (400) @(negedge clk_i);
      hold_ack = hold_req;
    end else begin
      out_if.ready = $urandom_range(99) >= rx_idle;
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one transaction and wait until it is accepted.
  task automatic send(logic c, logic [7:0] p, logic [7:0] m);
    if (sent < 550) begin
      tx_idle = 17;
      rx_idle = 88;
    end else if (sent < 1100) begin
      tx_idle = 88;
      rx_idle = 17;
    end else begin
      tx_idle = 0;
      rx_idle = 0;
    end
    while ($urandom_range(99) < tx_idle) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid = 1'b1;
    in_if.cmd = c;
    in_if.pixel_value = p;
    in_if.mask_value = m;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  // Registers change only once every readout pixel has come back.
  task automatic write_reg(cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // One frame: geometry and threshold, loads with a share of known pixels, then readout.
  // A partial frame stops after a few loads; noise mixes in commands the phase ignores.
  task automatic run_frame(logic [7:0] wv, logic [7:0] hv, logic [7:0] th, int known_pct,
                           bit noise, int partial);
    int w, h, n;
    logic [7:0] m;
    w = (wv == 0) ? 1 : (wv > 128) ? 128 : wv;
    h = (hv == 0) ? 1 : (hv > 128) ? 128 : hv;
    n = w * h;
    write_reg(CFG_WIDTH, wv);
    write_reg(CFG_HEIGHT, hv);
    write_reg(CFG_THRESH, th);
    for (int i = 0; i < n; i++) begin
      if (partial >= 0 && i >= partial) return;
      if (noise && $urandom_range(99) < 8) send(1'b1, 8'($urandom), 8'($urandom));
      if ($urandom_range(99) < known_pct || th == 0) m = 8'($urandom_range(255, th));
      else m = 8'($urandom_range(th - 1, 0));
      send(1'b0, 8'($urandom), m);
    end
    // The receiver holds off from the first result while reads keep coming.
    if (hold_next) begin
      hold_next = 1'b0;
      hold_req++;
    end
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(99) < 8) send(1'b0, 8'($urandom), 8'($urandom));
      send(1'b1, 8'($urandom), 8'($urandom));
    end
    if (noise) send(1'b1, 8'hff, 8'hff);
  endtask

  initial begin
    int wv, hv, th;
    in_if.valid = 1'b0;
    in_if.cmd = 1'b0;
    in_if.pixel_value = '0;
    in_if.mask_value = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: single pixel, zero width, all known, only full masks, all unknown,
    // a frame cut short by a register write, and ignored commands.
    run_frame(8'd1, 8'd1, 8'd255, 50, 1'b1, -1);
    run_frame(8'd0, 8'd2, 8'd0, 0, 1'b0, -1);
    hold_next = 1'b1;
    run_frame(8'd3, 8'd1, 8'd255, 30, 1'b0, -1);
    run_frame(8'd2, 8'd2, 8'd128, 0, 1'b0, -1);
    run_frame(8'd3, 8'd3, 8'd100, 50, 1'b0, 4);

    // Random frames, mostly small, a few at the largest sizes.
    while (sent < ITEM_GOAL) begin
      if ($urandom_range(19) == 0) begin
        case ($urandom_range(3))
          0: begin wv = 255; hv = 1; end
          1: begin wv = 1; hv = 255; end
          2: begin wv = 128; hv = 0; end
          default: begin wv = 0; hv = 128; end
        endcase
      end else begin
        wv = $urandom_range(8, 1);
        hv = $urandom_range(8, 1);
      end
      case ($urandom_range(5))
        0: th = 0;
        1: th = 255;
        default: th = $urandom_range(255);
      endcase
      run_frame(8'(wv), 8'(hv), 8'(th), $urandom_range(100), $urandom_range(9) == 0,
                ($urandom_range(29) == 0) ? $urandom_range(3) : -1);
    end

    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== masked_image_diffusion_fill.f =====
+incdir+src
src/mdf_pkg.sv
src/mdf_in_if.sv
src/mdf_out_if.sv
src/masked_image_diffusion_fill.sv
verif/mdf_fill_checker.sv
verif/tb.sv
